### sv/median_filter_3x3_assert.svh
// median_filter_3x3_assert.svh: assertion macros for the median filter checks.
// Depends on nothing; taken in by the port checker.
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

// Same-edge implication, disabled while reset is asserted.
`define MF3_ASSERT_NOW(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-edge implication, disabled while reset is asserted.
`define MF3_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/mf3_pkg.sv
// mf3_pkg: shared constants, register indexes and types of the 3x3 median filter.
// Used by every module of the block; depends on nothing.
package mf3_pkg;

	localparam int PIX_W            = 8;
	localparam int WIN_TAPS         = 9;
	localparam int DEF_MAX_WIDTH    = 1024;
	localparam int DEF_MAX_HEIGHT   = 4096;
	localparam int DEF_IMAGE_WIDTH  = 640;
	localparam int DEF_IMAGE_HEIGHT = 480;
	localparam int IMG_W_W          = 11;
	localparam int IMG_H_W          = 13;
	localparam int CFG_DATA_W       = 13;
	localparam int CFG_IDX_W        = 2;
	localparam int Q_DEPTH          = 4;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	typedef logic [PIX_W-1:0] mf3_pix_t;

	typedef struct packed {
		logic med;
		logic bord;
		logic eof;
	} mf3_kind_t;

	typedef struct packed {
		mf3_pix_t top;
		mf3_pix_t mid;
		mf3_pix_t pix;
	} mf3_col_t;

	typedef logic [WIN_TAPS-1:0][PIX_W-1:0] mf3_win_t;

endpackage

### sv/mf3_fifo.sv
// mf3_fifo: short register queue between the front and back of the median filter.
// Depends on mf3_pkg for the default depth.
module mf3_fifo #(
	parameter int DEPTH  = mf3_pkg::Q_DEPTH,
	parameter int DATA_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              not_empty
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CNTW-1:0]   count_q;

	assign full      = (count_q == CNTW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10: begin
					count_q <= count_q + CNTW'(1);
				end
				2'b01: begin
					count_q <= count_q - CNTW'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### sv/mf3_front.sv
// mf3_front: pixel intake, frame position, size registers and the two line stores.
// Classifies each pixel and pushes its column into the queue; depends on mf3_pkg.
module mf3_front #(
	parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT),
	localparam int QW = $bits(mf3_pkg::mf3_kind_t) + $bits(mf3_pkg::mf3_col_t) + RW + CW
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             pixel_valid,
	output logic                             pixel_ready,
	input  mf3_pkg::mf3_pix_t                pixel_in,
	output logic                             q_push,
	output logic [QW-1:0]                    q_data,
	input  logic                             q_full
);

	localparam int WDW  = $clog2(MAX_WIDTH + 1);
	localparam int HDW  = $clog2(MAX_HEIGHT + 1);
	localparam int WXW  = (mf3_pkg::IMG_W_W > WDW) ? mf3_pkg::IMG_W_W : WDW;
	localparam int HXW  = (mf3_pkg::IMG_H_W > HDW) ? mf3_pkg::IMG_H_W : HDW;
	localparam int WRST = (mf3_pkg::DEF_IMAGE_WIDTH > MAX_WIDTH) ?
		MAX_WIDTH : mf3_pkg::DEF_IMAGE_WIDTH;
	localparam int HRST = (mf3_pkg::DEF_IMAGE_HEIGHT > MAX_HEIGHT) ?
		MAX_HEIGHT : mf3_pkg::DEF_IMAGE_HEIGHT;

	logic [WDW-1:0]      wlim_q;
	logic [HDW-1:0]      hlim_q;
	logic [CW-1:0]       c_q;
	logic [RW-1:0]       r_q;
	logic [WXW-1:0]      wr_w;
	logic [HXW-1:0]      wr_h;
	logic [WDW-1:0]      w_clamp;
	logic [HDW-1:0]      h_clamp;
	logic                cfg_w_hit;
	logic                cfg_h_hit;
	logic                acc;
	logic                adv_s1;
	logic                col_last;
	logic                row_last;
	mf3_pkg::mf3_kind_t  kind_in;

	logic                v_s1;
	mf3_pkg::mf3_pix_t   pix_s1;
	mf3_pkg::mf3_pix_t   top_s1;
	mf3_pkg::mf3_pix_t   mid_s1;
	logic [RW-1:0]       r_s1;
	logic [CW-1:0]       c_s1;
	mf3_pkg::mf3_kind_t  kind_s1;

	mf3_pkg::mf3_pix_t   line_upper_q  [MAX_WIDTH];
	mf3_pkg::mf3_pix_t   line_middle_q [MAX_WIDTH];

	always_comb begin
		wr_w = WXW'(cfg_data[mf3_pkg::IMG_W_W-1:0]);
		wr_h = HXW'(cfg_data[mf3_pkg::IMG_H_W-1:0]);
		if (wr_w == '0) begin
			w_clamp = WDW'(1);
		end else if (wr_w > WXW'(MAX_WIDTH)) begin
			w_clamp = WDW'(MAX_WIDTH);
		end else begin
			w_clamp = WDW'(wr_w);
		end
		if (wr_h == '0) begin
			h_clamp = HDW'(1);
		end else if (wr_h > HXW'(MAX_HEIGHT)) begin
			h_clamp = HDW'(MAX_HEIGHT);
		end else begin
			h_clamp = HDW'(wr_h);
		end
	end

	assign cfg_w_hit = cfg_write && (cfg_index == mf3_pkg::REG_IMAGE_WIDTH);
	assign cfg_h_hit = cfg_write && (cfg_index == mf3_pkg::REG_IMAGE_HEIGHT);

	assign col_last = ((WDW'(c_q) + WDW'(1)) == wlim_q);
	assign row_last = ((HDW'(r_q) + HDW'(1)) == hlim_q);

	always_comb begin
		kind_in.med  = (r_q >= RW'(2)) && (c_q >= CW'(2));
		kind_in.bord = (r_q == '0) || (c_q == '0) || row_last || col_last;
		kind_in.eof  = row_last && col_last;
	end

	assign pixel_ready = !v_s1 || !q_full;
	assign acc         = pixel_valid && pixel_ready;
	assign adv_s1      = v_s1 && !q_full;
	assign q_push      = adv_s1;
	assign q_data      = {kind_s1, top_s1, mid_s1, pix_s1, r_s1, c_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlim_q <= WDW'(WRST);
			hlim_q <= HDW'(HRST);
			c_q    <= '0;
			r_q    <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (cfg_w_hit) begin
				wlim_q <= w_clamp;
			end
			if (cfg_h_hit) begin
				hlim_q <= h_clamp;
			end
			if (cfg_w_hit || cfg_h_hit) begin
				c_q <= '0;
				r_q <= '0;
			end else if (acc) begin
				if (col_last) begin
					c_q <= '0;
					r_q <= row_last ? '0 : r_q + RW'(1);
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// rotate the column down: middle row moves to upper, new pixel to middle
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= pixel_in;
			r_s1    <= r_q;
			c_s1    <= c_q;
			kind_s1 <= kind_in;
			top_s1  <= line_upper_q[c_q];
			mid_s1  <= line_middle_q[c_q];
		end
		if (adv_s1) begin
			line_upper_q[c_s1]  <= mid_s1;
			line_middle_q[c_s1] <= pix_s1;
		end
	end

endmodule

### sv/mf3_back.sv
// mf3_back: 3x3 window, pipelined median selection network and result output register.
// Pops columns from the queue; depends on mf3_pkg.
module mf3_back #(
	parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT),
	localparam int QW = $bits(mf3_pkg::mf3_kind_t) + $bits(mf3_pkg::mf3_col_t) + RW + CW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  logic [QW-1:0]     q_data,
	output logic              q_pop,
	output logic              result_valid,
	input  logic              result_ready,
	output mf3_pkg::mf3_pix_t out_value,
	output logic [RW-1:0]     out_row,
	output logic [CW-1:0]     out_col,
	output logic              last_of_run,
	output logic              end_of_frame
);

	localparam int KW = $bits(mf3_pkg::mf3_kind_t);
	localparam int LW = $bits(mf3_pkg::mf3_col_t);

	function automatic mf3_pkg::mf3_win_t cx(input mf3_pkg::mf3_win_t v, input int lo,
		input int hi);
		mf3_pkg::mf3_win_t res;
		res = v;
		if (v[lo] > v[hi]) begin
			res[lo] = v[hi];
			res[hi] = v[lo];
		end
		return res;
	endfunction

	mf3_pkg::mf3_kind_t q_kind;
	mf3_pkg::mf3_col_t  q_col;
	logic [RW-1:0]      q_r;
	logic [CW-1:0]      q_c;
	logic               adv;

	logic               v_s1, v_s2, v_s3;
	mf3_pkg::mf3_win_t  win_s1, win_s2, win_s3;
	mf3_pkg::mf3_kind_t kind_s1, kind_s2, kind_s3;
	logic [RW-1:0]      r_s1, r_s2, r_s3;
	logic [CW-1:0]      c_s1, c_s2, c_s3;
	mf3_pkg::mf3_win_t  net_a, net_b, net_c;

	logic               result_valid_q;
	logic               pend_q;
	mf3_pkg::mf3_pix_t  value_q;
	logic [RW-1:0]      row_q, prow_q;
	logic [CW-1:0]      col_q, pcol_q;
	logic               last_q, eof_q, peof_q;

	assign q_kind = mf3_pkg::mf3_kind_t'(q_data[QW-1 -: KW]);
	assign q_col  = mf3_pkg::mf3_col_t'(q_data[CW+RW +: LW]);
	assign q_r    = q_data[CW +: RW];
	assign q_c    = q_data[CW-1:0];

	assign adv   = !result_valid_q || (result_ready && !pend_q);
	assign q_pop = adv && q_valid;

	always_comb begin
		net_a = win_s1;
		net_a = cx(net_a, 1, 2);
		net_a = cx(net_a, 4, 5);
		net_a = cx(net_a, 7, 8);
		net_a = cx(net_a, 0, 1);
		net_a = cx(net_a, 3, 4);
		net_a = cx(net_a, 6, 7);
		net_a = cx(net_a, 1, 2);
		net_a = cx(net_a, 4, 5);
		net_a = cx(net_a, 7, 8);
	end

	always_comb begin
		net_b = win_s2;
		net_b = cx(net_b, 0, 3);
		net_b = cx(net_b, 5, 8);
		net_b = cx(net_b, 4, 7);
		net_b = cx(net_b, 3, 6);
		net_b = cx(net_b, 1, 4);
		net_b = cx(net_b, 2, 5);
		net_b = cx(net_b, 4, 7);
	end

	always_comb begin
		net_c = win_s3;
		net_c = cx(net_c, 4, 2);
		net_c = cx(net_c, 6, 4);
		net_c = cx(net_c, 4, 2);
	end

	// shift the window one column left, newest column at the top taps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			win_s1 <= '0;
		end else if (adv) begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (q_pop) begin
				win_s1 <= {q_col.pix, q_col.mid, q_col.top, win_s1[8:3]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (q_pop) begin
				kind_s1 <= q_kind;
				r_s1    <= q_r;
				c_s1    <= q_c;
			end
			win_s2  <= net_a;
			kind_s2 <= kind_s1;
			r_s2    <= r_s1;
			c_s2    <= c_s1;
			win_s3  <= net_b;
			kind_s3 <= kind_s2;
			r_s3    <= r_s2;
			c_s3    <= c_s2;
		end
	end

	// hold the border result behind a median until the median transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			pend_q         <= 1'b0;
			value_q        <= '0;
			row_q          <= '0;
			col_q          <= '0;
			last_q         <= 1'b0;
			eof_q          <= 1'b0;
			prow_q         <= '0;
			pcol_q         <= '0;
			peof_q         <= 1'b0;
		end else begin
			priority if (result_valid_q && result_ready && pend_q) begin
				value_q <= '0;
				row_q   <= prow_q;
				col_q   <= pcol_q;
				last_q  <= 1'b1;
				eof_q   <= peof_q;
				pend_q  <= 1'b0;
			end else if (adv) begin
				if (v_s3 && kind_s3.med) begin
					result_valid_q <= 1'b1;
					value_q        <= net_c[4];
					row_q          <= r_s3 - RW'(1);
					col_q          <= c_s3 - CW'(1);
					last_q         <= !kind_s3.bord;
					eof_q          <= 1'b0;
					pend_q         <= kind_s3.bord;
					prow_q         <= r_s3;
					pcol_q         <= c_s3;
					peof_q         <= kind_s3.eof;
				end else if (v_s3 && kind_s3.bord) begin
					result_valid_q <= 1'b1;
					value_q        <= '0;
					row_q          <= r_s3;
					col_q          <= c_s3;
					last_q         <= 1'b1;
					eof_q          <= kind_s3.eof;
					pend_q         <= 1'b0;
				end else begin
					result_valid_q <= 1'b0;
				end
			end
		end
	end

	assign result_valid = result_valid_q;
	assign out_value    = value_q;
	assign out_row      = row_q;
	assign out_col      = col_q;
	assign last_of_run  = last_q;
	assign end_of_frame = eof_q;

endmodule

### sv/median_filter_3x3.sv
// median_filter_3x3: top level of the streaming 3x3 median filter.
// Joins mf3_front, mf3_fifo and mf3_back; depends on mf3_pkg.
//
// Pixels enter in raster order on pixel_valid/pixel_ready/pixel_in. Each
// transaction on result_valid/result_ready gives one filtered pixel with its
// row and column: the median of the 3x3 neighbourhood for interior pixels,
// 0 for pixels on the outer rows and columns. last_of_run marks the final
// result caused by one input pixel, end_of_frame the final result of a frame.
// cfg_write with cfg_index/cfg_data sets image width or height and restarts
// the frame at row 0, column 0; write only while the filter is idle.
// A pixel's first result passes front register, queue, window register,
// three network stages and output register on its way to result_valid.
// Throughput: one pixel and one result per cycle while result_ready is high,
// set by the single output register; a pixel in the bottom row or right
// column (row, column >= 2) gives two results, so the 4-entry queue fills.
// Reset: size returns to 640 x 480, position to row 0, column 0, pipeline
// empty; line stores are not cleared and need no clearing pass.
// When the receiver stalls the output holds, the back pipeline stops and
// the queue fills; pixel_ready then drops until space returns.
module median_filter_3x3 #(
	parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           pixel_valid,
	output logic                           pixel_ready,
	input  logic [mf3_pkg::PIX_W-1:0]      pixel_in,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [mf3_pkg::PIX_W-1:0]      out_value,
	output logic [RW-1:0]                  out_row,
	output logic [CW-1:0]                  out_col,
	output logic                           last_of_run,
	output logic                           end_of_frame
);

	localparam int QW = $bits(mf3_pkg::mf3_kind_t) + $bits(mf3_pkg::mf3_col_t) + RW + CW;

	logic          q_push;
	logic [QW-1:0] q_push_data;
	logic          q_full;
	logic          q_pop;
	logic [QW-1:0] q_pop_data;
	logic          q_valid;

	mf3_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_in    (pixel_in),
		.q_push      (q_push),
		.q_data      (q_push_data),
		.q_full      (q_full)
	);

	mf3_fifo #(
		.DEPTH  (mf3_pkg::Q_DEPTH),
		.DATA_W (QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.not_empty (q_valid)
	);

	mf3_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_pop_data),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_value    (out_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame)
	);

endmodule

### sv/mf3_port_check.sv
// mf3_port_check: port-level checks on the result channel of the median filter.
// Uses median_filter_3x3_assert.svh and mf3_pkg; bound to median_filter_3x3.
`include "median_filter_3x3_assert.svh"

module mf3_port_check #(
	parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT)
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      result_valid,
	input logic                      result_ready,
	input logic [mf3_pkg::PIX_W-1:0] out_value,
	input logic [RW-1:0]             out_row,
	input logic [CW-1:0]             out_col,
	input logic                      last_of_run,
	input logic                      end_of_frame
);

	`MF3_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready,
		result_valid && $stable(out_value) && $stable(out_row) && $stable(out_col),
		"result must hold while the receiver stalls")

	`MF3_ASSERT_NOW(a_eof_is_border, clk, arst_n, result_valid && end_of_frame,
		last_of_run && (out_value == '0), "frame end must be a closing border result")

	`MF3_ASSERT_NEXT(a_median_then_border, clk, arst_n,
		result_valid && result_ready && !last_of_run,
		result_valid && last_of_run && (out_value == '0) &&
		(out_row == $past(out_row) + RW'(1)) && (out_col == $past(out_col) + CW'(1)),
		"border result must follow its median at the next position")

	`MF3_ASSERT_NOW(a_empty_after_reset, clk, arst_n, $rose(arst_n), !result_valid,
		"result channel must be empty on leaving reset")

endmodule

bind median_filter_3x3 mf3_port_check #(
	.MAX_WIDTH  (MAX_WIDTH),
	.MAX_HEIGHT (MAX_HEIGHT)
) u_port_check (.*);
